>>> sv/lpvm_pkg.sv
// Shared types and constants for the looping PCM voice mixer.
// Used by the interfaces, the sample memory, the top level and the checker.
package lpvm_pkg;

	localparam int VOICES       = 8;
	localparam int SAMPLE_DEPTH = 16384;
	localparam int SAMPLE_BITS  = 16;

	localparam int ADDR_W  = $clog2(SAMPLE_DEPTH);
	localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int POS_W   = 15;
	localparam int LOOP_W  = 14;
	localparam int PMODE_W = 3;
	localparam int SUM_W   = SAMPLE_BITS + VIDX_W + 1;
	localparam int MAP_W   = 8;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_VOICE = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [PMODE_W-1:0] PM_NORMAL       = 3'd0;
	localparam logic [PMODE_W-1:0] PM_ONESHOT      = 3'd1;
	localparam logic [PMODE_W-1:0] PM_LOOP         = 3'd2;
	localparam logic [PMODE_W-1:0] PM_STREAM_INVAL = 3'd3;
	localparam logic [PMODE_W-1:0] PM_STREAM_AVAIL = 3'd4;

	typedef struct packed {
		logic [1:0]         mode;
		logic [13:0]        sample_addr;
		logic signed [15:0] sample_data;
		logic [2:0]         voice;
		logic [13:0]        start_pos;
		logic [14:0]        end_pos;
		logic [13:0]        loop_start;
		logic [14:0]        next_loop_end;
		logic [2:0]         pmode_sel;
		logic               paused;
		logic               active;
	} req_t;

	typedef struct packed {
		logic signed [15:0] mixed_sample;
		logic               clipped;
		logic [7:0]         active_voices;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIX,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

endpackage

>>> sv/lpvm_if.sv
// Valid/ready channel interfaces for the mixer's request and response sides.
// Depends on lpvm_pkg for the payload structs.
interface lpvm_req_if;
	logic          valid;
	logic          ready;
	lpvm_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lpvm_rsp_if;
	logic          valid;
	logic          ready;
	lpvm_pkg::rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> sv/lpvm_sample_mem.sv
// Sample word memory: one write port, one registered read port.
// Depends on lpvm_pkg for depth and word width.
module lpvm_sample_mem (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [lpvm_pkg::ADDR_W-1:0]          waddr,
	input  logic signed [lpvm_pkg::SAMPLE_BITS-1:0] wdata,
	input  logic                                 re,
	input  logic [lpvm_pkg::ADDR_W-1:0]          raddr,
	output logic signed [lpvm_pkg::SAMPLE_BITS-1:0] rdata
);

	logic [lpvm_pkg::SAMPLE_BITS-1:0] mem_q [lpvm_pkg::SAMPLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/looping_pcm_voice_mixer.sv
// Top level of the looping PCM voice mixer: voice slot registers, mix sequencer, output register.
// Depends on lpvm_pkg, lpvm_if and lpvm_sample_mem.
//
// A sample load or a voice write gives no response. A frame tick visits the voice slots
// one per cycle through the single sample memory read port and a shared accumulator,
// then passes through the drain and flush states before the block is ready again; in
// flush it also waits for the previous response to be taken. The response register
// holds one finished frame while the next transaction is accepted.
module looping_pcm_voice_mixer (
	input  logic             clk,
	input  logic             arst_n,
	lpvm_req_if.sink         req,
	lpvm_rsp_if.source       rsp
);

	localparam logic [lpvm_pkg::VIDX_W-1:0] LAST_VOICE = lpvm_pkg::VIDX_W'(lpvm_pkg::VOICES - 1);

	lpvm_pkg::state_t state_q, state_d;

	logic [lpvm_pkg::VIDX_W-1:0] cur_q;
	logic                        rd_en_s1;
	logic signed [lpvm_pkg::SUM_W-1:0] sum_q;
	logic                        out_valid_q;
	lpvm_pkg::rsp_t              out_q;

	logic [lpvm_pkg::POS_W-1:0]   pos_q    [lpvm_pkg::VOICES];
	logic [lpvm_pkg::POS_W-1:0]   end_q    [lpvm_pkg::VOICES];
	logic [lpvm_pkg::LOOP_W-1:0]  lstart_q [lpvm_pkg::VOICES];
	logic [lpvm_pkg::POS_W-1:0]   nend_q   [lpvm_pkg::VOICES];
	logic [lpvm_pkg::PMODE_W-1:0] pmode_q  [lpvm_pkg::VOICES];
	logic [lpvm_pkg::VOICES-1:0]  paused_q;
	logic [lpvm_pkg::VOICES-1:0]  active_q;

	logic req_acc, tick_acc, load_acc, voice_acc;
	logic mix_en, out_load;
	logic play, hit_end, mem_re;
	logic [lpvm_pkg::POS_W-1:0]   pos_inc, n_pos, n_end;
	logic [lpvm_pkg::PMODE_W-1:0] n_pmode;
	logic                         n_paused, n_active;
	logic signed [lpvm_pkg::SAMPLE_BITS-1:0] rdata;
	logic clip;
	logic signed [lpvm_pkg::SAMPLE_BITS-1:0] sat;
	logic [lpvm_pkg::MAP_W-1:0] map;

	assign req_acc   = req.valid && req.ready;
	assign tick_acc  = req_acc && (req.data.mode == lpvm_pkg::KIND_TICK);
	assign load_acc  = req_acc && (req.data.mode == lpvm_pkg::KIND_LOAD)
		&& (int'(req.data.sample_addr) < lpvm_pkg::SAMPLE_DEPTH);
	assign voice_acc = req_acc && (req.data.mode == lpvm_pkg::KIND_VOICE)
		&& (int'(req.data.voice) < lpvm_pkg::VOICES);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpvm_pkg::ST_IDLE: begin
				if (tick_acc) begin
					state_d = lpvm_pkg::ST_MIX;
				end
			end
			lpvm_pkg::ST_MIX: begin
				if (cur_q == LAST_VOICE) begin
					state_d = lpvm_pkg::ST_DRAIN;
				end
			end
			lpvm_pkg::ST_DRAIN: begin
				state_d = lpvm_pkg::ST_FLUSH;
			end
			lpvm_pkg::ST_FLUSH: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = lpvm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpvm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = (state_q == lpvm_pkg::ST_IDLE);
		mix_en    = (state_q == lpvm_pkg::ST_MIX);
		out_load  = (state_q == lpvm_pkg::ST_FLUSH) && (!out_valid_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpvm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		play     = active_q[cur_q] && !paused_q[cur_q];
		pos_inc  = pos_q[cur_q] + 1'b1;
		hit_end  = (pos_inc >= end_q[cur_q]);
		n_pos    = pos_inc;
		n_end    = end_q[cur_q];
		n_pmode  = pmode_q[cur_q];
		n_paused = paused_q[cur_q];
		n_active = active_q[cur_q];
		if (hit_end) begin
			unique case (pmode_q[cur_q])
				lpvm_pkg::PM_NORMAL: begin
					n_pos    = lpvm_pkg::POS_W'(lstart_q[cur_q]);
					n_paused = 1'b1;
				end
				lpvm_pkg::PM_ONESHOT: begin
					n_paused = 1'b1;
					n_active = 1'b0;
				end
				lpvm_pkg::PM_LOOP: begin
					n_pos = lpvm_pkg::POS_W'(lstart_q[cur_q]);
					n_end = nend_q[cur_q];
				end
				lpvm_pkg::PM_STREAM_AVAIL: begin
					n_pos   = lpvm_pkg::POS_W'(lstart_q[cur_q]);
					n_end   = nend_q[cur_q];
					n_pmode = lpvm_pkg::PM_STREAM_INVAL;
				end
				default: begin
					n_paused = 1'b1;
				end
			endcase
		end
	end

	assign mem_re = mix_en && play && (int'(pos_q[cur_q]) < lpvm_pkg::SAMPLE_DEPTH);

	lpvm_sample_mem u_mem (
		.clk   (clk),
		.we    (load_acc),
		.waddr (req.data.sample_addr[lpvm_pkg::ADDR_W-1:0]),
		.wdata (req.data.sample_data),
		.re    (mem_re),
		.raddr (pos_q[cur_q][lpvm_pkg::ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lpvm_pkg::VOICES; i++) begin
				pos_q[i]    <= '0;
				end_q[i]    <= '0;
				lstart_q[i] <= '0;
				nend_q[i]   <= '0;
				pmode_q[i]  <= '0;
			end
			paused_q <= '0;
			active_q <= '0;
		end else if (voice_acc) begin
			pos_q[req.data.voice[lpvm_pkg::VIDX_W-1:0]]    <= lpvm_pkg::POS_W'(req.data.start_pos);
			end_q[req.data.voice[lpvm_pkg::VIDX_W-1:0]]    <= req.data.end_pos;
			lstart_q[req.data.voice[lpvm_pkg::VIDX_W-1:0]] <= req.data.loop_start;
			nend_q[req.data.voice[lpvm_pkg::VIDX_W-1:0]]   <= req.data.next_loop_end;
			pmode_q[req.data.voice[lpvm_pkg::VIDX_W-1:0]]  <= req.data.pmode_sel;
			paused_q[req.data.voice[lpvm_pkg::VIDX_W-1:0]] <= req.data.paused;
			active_q[req.data.voice[lpvm_pkg::VIDX_W-1:0]] <= req.data.active;
		end else if (mix_en && play) begin
			pos_q[cur_q]    <= n_pos;
			end_q[cur_q]    <= n_end;
			pmode_q[cur_q]  <= n_pmode;
			paused_q[cur_q] <= n_paused;
			active_q[cur_q] <= n_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			rd_en_s1 <= 1'b0;
		end else begin
			rd_en_s1 <= mem_re;
			if (tick_acc) begin
				cur_q <= '0;
			end else if (mix_en) begin
				cur_q <= cur_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			sum_q <= '0;
		end else if (rd_en_s1) begin
			sum_q <= sum_q + lpvm_pkg::SUM_W'(rdata);
		end
	end

	always_comb begin
		clip = !((&sum_q[lpvm_pkg::SUM_W-1:lpvm_pkg::SAMPLE_BITS-1])
			|| !(|sum_q[lpvm_pkg::SUM_W-1:lpvm_pkg::SAMPLE_BITS-1]));
		if (clip) begin
			sat = sum_q[lpvm_pkg::SUM_W-1]
				? {1'b1, {(lpvm_pkg::SAMPLE_BITS-1){1'b0}}}
				: {1'b0, {(lpvm_pkg::SAMPLE_BITS-1){1'b1}}};
		end else begin
			sat = sum_q[lpvm_pkg::SAMPLE_BITS-1:0];
		end
		map = '0;
		for (int i = 0; i < lpvm_pkg::MAP_W; i++) begin
			if (i < lpvm_pkg::VOICES) begin
				map[i] = active_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.mixed_sample  <= sat;
			out_q.clipped       <= clip;
			out_q.active_voices <= map;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

>>> sv/lpvm_checker.sv
// Port-level assertions for the looping PCM voice mixer, attached by a bind.
// Depends on lpvm_pkg and on the top level looping_pcm_voice_mixer.
module lpvm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic [1:0]     req_mode,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input lpvm_pkg::rsp_t rsp_data
);

	// A frame tick keeps the block busy on the following cycle.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req_mode == lpvm_pkg::KIND_TICK)) |=> !req_ready)
		else $error("ready stayed high after a frame tick transaction");

	// A new frame result only appears right after the mixer was busy finishing a tick.
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared while the block was idle");

	// A clipped frame carries one of the two saturation values.
	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.clipped) |->
			(rsp_data.mixed_sample == 16'sh7fff || rsp_data.mixed_sample == 16'sh8000))
		else $error("clipped frame does not hold a saturation value");

	// A stalled response transaction holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("stalled response changed");

endmodule

bind looping_pcm_voice_mixer lpvm_checker u_lpvm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_mode  (req.data.mode),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
